// ===== design/rbdu_pkg.sv =====
// ----------------------------------------------------------------------------
// rbdu_pkg
// Shared types and constants of the raw bank digit unpacker.
// ----------------------------------------------------------------------------
package rbdu_pkg;

	localparam int LANES     = 4;
	localparam int ADC_LANES = 2;
	localparam int CRATES    = 32;
	localparam int CHANNELS  = 64;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_TRIG   = 2'd1,
		PH_ADC    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_TRIG   = 2'd1,
		KIND_ADC    = 2'd2
	} kind_t;

	localparam logic REG_SKIP_TRIGGER = 1'b0;
	localparam logic REG_SKIP_ADC     = 1'b1;

	// what one lane finds for its entry
	typedef struct packed {
		logic [5:0] chan;
		logic [9:0] value;
		logic       hit;
	} lane_res_t;

	typedef struct packed {
		kind_t      kind;
		logic [4:0] crate;
		logic [3:0] card;
		logic [5:0] chan;
		logic [9:0] value;
		logic       gen_err;
		logic       sync_err;
		logic       link_err;
		logic       dup;
		logic       trunc;
	} result_t;

endpackage

// ===== design/rbdu_lane.sv =====
// ----------------------------------------------------------------------------
// rbdu_lane
// Decodes one trigger or ADC entry and looks its channel up in the seen row.
// ----------------------------------------------------------------------------
module rbdu_lane
	import rbdu_pkg::*;
(
	input  logic [15:0] entry,
	input  logic        is_adc,
	input  logic [63:0] row,
	output lane_res_t   res
);

	logic [5:0] chan;
	logic [9:0] value;

	always_comb begin
		if (is_adc) begin
			chan  = entry[15:10];
			value = entry[9:0];
		end else begin
			chan = entry[5:0];
			// p + 10*s
			unique case (entry[7:6])
				2'b00: value = 10'd0;
				2'b01: value = 10'd1;
				2'b10: value = 10'd10;
				2'b11: value = 10'd11;
				default: value = 10'd0;
			endcase
		end
	end

	assign res.chan  = chan;
	assign res.value = value;
	assign res.hit   = row[chan];

endmodule

// ===== design/rbdu_seen_map.sv =====
// ----------------------------------------------------------------------------
// rbdu_seen_map
// Per-event seen map, one 64-bit row per crate with a valid bit per row.
// ----------------------------------------------------------------------------
module rbdu_seen_map
	import rbdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic [4:0]  row_addr,
	input  logic        wr_en,
	input  logic [63:0] wr_row,
	output logic [63:0] rd_row
);

	logic [CHANNELS-1:0] rows_q [CRATES];
	logic [CRATES-1:0]   vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[row_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rows_q[row_addr] <= wr_row;
		end
	end

	// a row not written since event start reads as empty
	assign rd_row = vld_q[row_addr] ? rows_q[row_addr] : '0;

endmodule

// ===== design/raw_bank_digit_unpacker.sv =====
// ----------------------------------------------------------------------------
// raw_bank_digit_unpacker
// Parses raw bank words into status, trigger digit and ADC digit results.
// ----------------------------------------------------------------------------
// Each accepted word is decoded combinationally by four lanes that share the
// seen-map row of the current crate; its results (up to four) then leave the
// result buffer one per cycle while out_ready is high, all through the
// single output port. Full trigger words give four results and full ADC
// words two. The next word is taken in the cycle its predecessor's last
// result is handed over.
// Seen maps are cleared at event start in the same cycle, no sweep.
module raw_bank_digit_unpacker
	import rbdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic        last_word_of_bank,
	input  logic        first_bank_of_event,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [4:0]  crate_number,
	output logic [3:0]  card_number,
	output logic [5:0]  channel_number,
	output logic [9:0]  digit_value,
	output logic        general_error,
	output logic        sync_error,
	output logic        link_error,
	output logic        duplicate_cell,
	output logic        truncated,
	output logic        last_of_run
);

	logic       skip_trig_q, skip_adc_q;
	phase_t     phase_q, phase_d, eff_phase;
	logic [6:0] tleft_q, tleft_d, aleft_q, aleft_d;
	logic [4:0] crate_q, crate_d;

	result_t    buf_q [LANES];
	result_t    res_d [LANES];
	logic [2:0] cnt_q, n_d;
	logic [1:0] rd_q;

	logic       fire_in, fire_out, is_adc, trunc_d;
	logic [2:0] take;
	logic [LANES-1:0] lane_act;
	logic [LANES-1:0] lane_dup;
	lane_res_t  lane_res [LANES];
	logic [63:0] trig_row, adc_row, cur_row, set_mask;
	logic       trig_we, adc_we;

	assign fire_in  = in_valid & in_ready;
	assign fire_out = out_valid & out_ready;
	assign in_ready = (cnt_q == 3'd0) | ((cnt_q == 3'd1) & out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_trig_q <= 1'b0;
			skip_adc_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SKIP_TRIGGER: skip_trig_q <= cfg_data;
				REG_SKIP_ADC:     skip_adc_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_phase = first_bank_of_event ? PH_HEADER : phase_q;
	assign is_adc    = (eff_phase == PH_ADC);
	assign cur_row   = is_adc ? adc_row : trig_row;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [15:0] entry;
		if (i < ADC_LANES) begin : g_wide
			assign entry = is_adc ? data_word[16*i +: 16] : {8'h00, data_word[8*i +: 8]};
		end else begin : g_narrow
			assign entry = {8'h00, data_word[8*i +: 8]};
		end
		rbdu_lane u_lane (
			.entry  (entry),
			.is_adc (is_adc),
			.row    (cur_row),
			.res    (lane_res[i])
		);
	end

	// merge: a lane also duplicates an earlier active lane of the same word
	always_comb begin
		set_mask = '0;
		for (int i = 0; i < LANES; i++) begin
			lane_dup[i] = lane_res[i].hit;
			for (int j = 0; j < i; j++) begin
				if (lane_act[j] && lane_res[j].chan == lane_res[i].chan) begin
					lane_dup[i] = 1'b1;
				end
			end
			if (lane_act[i]) begin
				set_mask[lane_res[i].chan] = 1'b1;
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		tleft_d  = tleft_q;
		aleft_d  = aleft_q;
		crate_d  = crate_q;
		take     = 3'd0;
		lane_act = '0;
		n_d      = 3'd0;
		for (int i = 0; i < LANES; i++) begin
			res_d[i]          = '0;
			res_d[i].kind     = is_adc ? KIND_ADC : KIND_TRIG;
			res_d[i].crate    = crate_q;
			res_d[i].chan     = lane_res[i].chan;
			res_d[i].value    = lane_res[i].value;
			res_d[i].dup      = lane_dup[i];
		end
		unique case (eff_phase)
			PH_TRIG: begin
				take    = (tleft_q < 7'd4) ? tleft_q[2:0] : 3'd4;
				tleft_d = tleft_q - {4'b0, take};
				if (tleft_d == 7'd0) begin
					phase_d = (aleft_q != 7'd0) ? PH_ADC : PH_HEADER;
				end
				if (!skip_trig_q) begin
					n_d = take;
					for (int i = 0; i < LANES; i++) begin
						lane_act[i] = (3'(i) < take);
					end
				end
			end
			PH_ADC: begin
				take    = (aleft_q < 7'd2) ? aleft_q[2:0] : 3'd2;
				aleft_d = aleft_q - {4'b0, take};
				if (aleft_d == 7'd0) begin
					phase_d = PH_HEADER;
				end
				if (!skip_adc_q) begin
					n_d = take;
					for (int i = 0; i < LANES; i++) begin
						lane_act[i] = (3'(i) < take);
					end
				end
			end
			default: begin
				tleft_d = data_word[6:0];
				aleft_d = data_word[13:7];
				crate_d = data_word[22:18];
				res_d[0]          = '0;
				res_d[0].kind     = KIND_STATUS;
				res_d[0].crate    = data_word[22:18];
				res_d[0].card     = data_word[17:14];
				res_d[0].gen_err  = data_word[23];
				res_d[0].sync_err = data_word[28];
				res_d[0].link_err = data_word[29];
				n_d = 3'd1;
				if (tleft_d != 7'd0) begin
					phase_d = PH_TRIG;
				end else if (aleft_d != 7'd0) begin
					phase_d = PH_ADC;
				end else begin
					phase_d = PH_HEADER;
				end
			end
		endcase
		trunc_d = last_word_of_bank && (tleft_d != 7'd0 || aleft_d != 7'd0);
		if (last_word_of_bank) begin
			phase_d = PH_HEADER;
			tleft_d = 7'd0;
			aleft_d = 7'd0;
		end
		// bank cut short in skip mode still reports once
		if (trunc_d && n_d == 3'd0) begin
			res_d[0]       = '0;
			res_d[0].kind  = KIND_STATUS;
			res_d[0].crate = crate_d;
			n_d = 3'd1;
		end
		for (int i = 0; i < LANES; i++) begin
			res_d[i].trunc = trunc_d;
		end
	end

	assign trig_we = fire_in && (eff_phase == PH_TRIG) && (lane_act != '0);
	assign adc_we  = fire_in && (eff_phase == PH_ADC) && (lane_act != '0);

	rbdu_seen_map u_trig_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (fire_in & first_bank_of_event),
		.row_addr (crate_q),
		.wr_en    (trig_we),
		.wr_row   (trig_row | set_mask),
		.rd_row   (trig_row)
	);

	rbdu_seen_map u_adc_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (fire_in & first_bank_of_event),
		.row_addr (crate_q),
		.wr_en    (adc_we),
		.wr_row   (adc_row | set_mask),
		.rd_row   (adc_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			tleft_q <= '0;
			aleft_q <= '0;
			crate_q <= '0;
		end else if (fire_in) begin
			phase_q <= phase_d;
			tleft_q <= tleft_d;
			aleft_q <= aleft_d;
			crate_q <= crate_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (fire_in) begin
			cnt_q <= n_d;
			rd_q  <= '0;
		end else if (fire_out) begin
			cnt_q <= cnt_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_in) begin
			buf_q <= res_d;
		end
	end

	assign out_valid      = (cnt_q != 3'd0);
	assign kind           = buf_q[rd_q].kind;
	assign crate_number   = buf_q[rd_q].crate;
	assign card_number    = buf_q[rd_q].card;
	assign channel_number = buf_q[rd_q].chan;
	assign digit_value    = buf_q[rd_q].value;
	assign general_error  = buf_q[rd_q].gen_err;
	assign sync_error     = buf_q[rd_q].sync_err;
	assign link_error     = buf_q[rd_q].link_err;
	assign duplicate_cell = buf_q[rd_q].dup;
	assign truncated      = buf_q[rd_q].trunc;
	assign last_of_run    = (cnt_q == 3'd1);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(LANES))
		else $error("result count beyond buffer depth");

	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		fire_in |-> cnt_q <= 3'd1)
		else $error("transaction accepted with results still pending");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_out && last_of_run && !fire_in) |=> !out_valid)
		else $error("results left after last of run");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, rd_q} + cnt_q) <= 3'(LANES))
		else $error("read pointer runs past loaded results");

endmodule
